### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FFCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FFCA_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define FFCA_ASSERT(label, clk, rst_n, prop, msg)

`define FFCA_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

### hdl/ffca_pkg.sv
package ffca_pkg;

    localparam int CAPACITY  = 64;
    localparam int GROW_STEP = 10;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int LEN_W     = $clog2(CAPACITY + 1);
    localparam int CELL_W    = 8;
    localparam int RESET_LEN = (GROW_STEP > CAPACITY) ? CAPACITY : GROW_STEP;

    localparam logic [CELL_W-1:0] FREE_CODE = 8'h5F;
    localparam logic [CELL_W-1:0] STOP_CODE = 8'h40;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // microprogram steps
    localparam int N_STEPS = 19;
    localparam int STEP_W  = $clog2(N_STEPS);
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_FETCH   = 5'd0;
    localparam t_step S_DISP_A  = 5'd1;
    localparam t_step S_DISP_F  = 5'd2;
    localparam t_step S_CHK_RNG = 5'd3;
    localparam t_step S_DISP_W  = 5'd4;
    localparam t_step S_RD0     = 5'd5;
    localparam t_step S_RD1     = 5'd6;
    localparam t_step S_WR      = 5'd7;
    localparam t_step S_RANGE   = 5'd8;
    localparam t_step S_A0      = 5'd9;
    localparam t_step S_A_SCAN  = 5'd10;
    localparam t_step S_A_HIT   = 5'd11;
    localparam t_step S_A_CHKG  = 5'd12;
    localparam t_step S_A_GROW  = 5'd13;
    localparam t_step S_A_RPRM  = 5'd14;
    localparam t_step S_NOFIT   = 5'd15;
    localparam t_step S_F0      = 5'd16;
    localparam t_step S_F_SCAN  = 5'd17;
    localparam t_step S_EMIT    = 5'd18;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_ALLOC,
        C_FREE,
        C_WRITE,
        C_ADDR_OOR,
        C_SCAN_END,
        C_HIT,
        C_NO_GROW,
        C_FREE_END,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic ready;
        logic rd_en;
        logic wr_en;
        logic scan;
        logic free_clr;
        logic grow;
        logic cap_rd;
        logic set_range;
        logic set_nofit;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic is_alloc;
        logic is_free;
        logic is_write;
        logic addr_oor;
        logic scan_end;
        logic hit;
        logic no_grow;
        logic free_end;
        logic out_free;
    } t_flags;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  hold;
        t_ctrl ctrl;
    } t_uword;

    // control store: on cond jump to target, else hold or go to the next step
    function automatic t_uword ucode_rom(input t_step s);
        t_uword w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.target = S_FETCH;
        case (s)
            S_FETCH: begin
                w.ctrl.ready = 1'b1;
                w.cond       = C_IN_VALID;
                w.target     = S_DISP_A;
                w.hold       = 1'b1;
            end
            S_DISP_A: begin
                w.cond   = C_ALLOC;
                w.target = S_A0;
            end
            S_DISP_F: begin
                w.cond   = C_FREE;
                w.target = S_F0;
            end
            S_CHK_RNG: begin
                w.cond   = C_ADDR_OOR;
                w.target = S_RANGE;
            end
            S_DISP_W: begin
                w.cond   = C_WRITE;
                w.target = S_WR;
            end
            S_RD0: begin
                w.ctrl.rd_en = 1'b1;
                w.cond       = C_NEVER;
            end
            S_RD1: begin
                w.ctrl.cap_rd = 1'b1;
                w.target      = S_EMIT;
            end
            S_WR: begin
                w.ctrl.wr_en = 1'b1;
                w.target     = S_EMIT;
            end
            S_RANGE: begin
                w.ctrl.set_range = 1'b1;
                w.target         = S_EMIT;
            end
            S_A0: begin
                w.ctrl.rd_en = 1'b1;
                w.cond       = C_NEVER;
            end
            S_A_SCAN: begin
                w.ctrl.rd_en = 1'b1;
                w.ctrl.scan  = 1'b1;
                w.cond       = C_SCAN_END;
                w.target     = S_A_HIT;
                w.hold       = 1'b1;
            end
            S_A_HIT: begin
                w.cond   = C_HIT;
                w.target = S_EMIT;
            end
            S_A_CHKG: begin
                w.cond   = C_NO_GROW;
                w.target = S_NOFIT;
            end
            S_A_GROW: begin
                w.ctrl.grow = 1'b1;
                w.cond      = C_NEVER;
            end
            S_A_RPRM: begin
                w.ctrl.rd_en = 1'b1;
                w.target     = S_A_SCAN;
            end
            S_NOFIT: begin
                w.ctrl.set_nofit = 1'b1;
                w.target         = S_EMIT;
            end
            S_F0: begin
                w.ctrl.rd_en = 1'b1;
                w.cond       = C_ADDR_OOR;
                w.target     = S_EMIT;
            end
            S_F_SCAN: begin
                w.ctrl.rd_en    = 1'b1;
                w.ctrl.free_clr = 1'b1;
                w.cond          = C_FREE_END;
                w.target        = S_EMIT;
                w.hold          = 1'b1;
            end
            S_EMIT: begin
                w.ctrl.out_load = 1'b1;
                w.cond          = C_OUT_FREE;
                w.target        = S_FETCH;
                w.hold          = 1'b1;
            end
            default: begin
                w.target = S_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

### hdl/ffca_if.sv
interface ffca_in_if import ffca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [LEN_W-1:0]  alloc_size;
    logic [ADDR_W-1:0] cell_address;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, action, alloc_size, cell_address, cell_value, input ready);
    modport sink   (input valid, action, alloc_size, cell_address, cell_value, output ready);
endinterface

interface ffca_out_if import ffca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [LEN_W-1:0]  position;
    logic [CELL_W-1:0] read_value;
    logic [LEN_W-1:0]  length_in_use;

    modport source (output valid, status, position, read_value, length_in_use, input ready);
    modport sink   (input valid, status, position, read_value, length_in_use, output ready);
endinterface

### hdl/ffca_cell_mem.sv
module ffca_cell_mem import ffca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic              i_clr,
    input  logic [ADDR_W-1:0] i_caddr,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CELL_W-1:0] o_cell
);

    logic [CELL_W-1:0] r_mem [CAPACITY];
    logic [CAPACITY-1:0] r_vld;
    logic [CELL_W-1:0] r_q;
    logic              r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    // a cell never written since reset or last freed reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_clr) begin
                r_vld[i_caddr] <= 1'b0;
            end
        end
        if (i_re) begin
            r_q_vld <= r_vld[i_raddr];
        end
    end

    assign o_cell = r_q_vld ? r_q : FREE_CODE;

endmodule

### hdl/ffca_useq.sv
`include "assert_macros.svh"

module ffca_useq import ffca_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword uword;
    logic   cond_true;

    assign uword  = ucode_rom(r_step);
    assign o_ctrl = uword.ctrl;

    always_comb begin
        case (uword.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_IN_VALID: cond_true = i_flags.in_valid;
            C_ALLOC:    cond_true = i_flags.is_alloc;
            C_FREE:     cond_true = i_flags.is_free;
            C_WRITE:    cond_true = i_flags.is_write;
            C_ADDR_OOR: cond_true = i_flags.addr_oor;
            C_SCAN_END: cond_true = i_flags.scan_end;
            C_HIT:      cond_true = i_flags.hit;
            C_NO_GROW:  cond_true = i_flags.no_grow;
            C_FREE_END: cond_true = i_flags.free_end;
            C_OUT_FREE: cond_true = i_flags.out_free;
            default:    cond_true = 1'b1;
        endcase
    end

    always_comb begin
        if (cond_true) begin
            n_step = uword.target;
        end else if (uword.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    `FFCA_ASSERT(a_step_range, i_clk, i_rst_n, r_step < STEP_W'(N_STEPS), "step counter out of program")
    `FFCA_ASSERT(a_accept_dispatch, i_clk, i_rst_n, o_ctrl.ready && i_flags.in_valid |=> r_step == S_DISP_A, "accepted word not dispatched")
    `FFCA_NEVER(a_rd_wr_clash, i_clk, i_rst_n, o_ctrl.wr_en && o_ctrl.rd_en, "cell read and write in one step")

endmodule

### hdl/first_fit_cell_allocator.sv
// steps from accept to result: write and read check the range first; free clears cells
// through the stop code or to the end of the length in use; alloc scans cells and, on
// a miss, grows the length in use and scans again, or reports no fit
// one word in flight, one cell scanned a cycle; next word taken while a result waits
// reset (synchronous, active low) marks every cell free at once, sets the length
// in use to 10 and grow_on_miss to 1; the block is ready in the first cycle after it
`include "assert_macros.svh"

module first_fit_cell_allocator import ffca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    ffca_in_if.sink    i_item,
    ffca_out_if.source o_result
);

    t_ctrl  ctrl;
    t_flags flags;

    logic              r_grow;
    logic [LEN_W-1:0]  r_len;
    logic [1:0]        r_act;
    logic [LEN_W-1:0]  r_size;
    logic [CELL_W-1:0] r_val;
    logic [LEN_W-1:0]  r_addr;
    logic [LEN_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_run_len;
    logic [LEN_W-1:0]  r_run_start;
    logic              r_hit;
    logic [1:0]        r_status;
    logic [LEN_W-1:0]  r_pos;
    logic [CELL_W-1:0] r_rd;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [LEN_W-1:0]  r_out_pos;
    logic [CELL_W-1:0] r_out_rd;
    logic [LEN_W-1:0]  r_out_len;

    logic [CELL_W-1:0] cell_q;
    logic              cell_free;
    logic              scan_ok;
    logic              size_zero;
    logic [LEN_W-1:0]  run_next;
    logic [LEN_W-1:0]  start_next;
    logic              hit_now;
    logic [LEN_W-1:0]  pos_now;
    logic [LEN_W:0]    grow_sum;
    logic [LEN_W-1:0]  n_len;
    logic              accept;
    logic              out_free;

    ffca_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    ffca_cell_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ctrl.wr_en),
        .i_waddr (r_addr[ADDR_W-1:0]),
        .i_wdata (r_val),
        .i_clr   (ctrl.free_clr && scan_ok),
        .i_caddr (r_idx[ADDR_W-1:0]),
        .i_re    (ctrl.rd_en),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_cell  (cell_q)
    );

    assign accept    = ctrl.ready && i_item.valid;
    assign out_free  = !r_out_valid || o_result.ready;
    assign cell_free = (cell_q == FREE_CODE);
    assign scan_ok   = (r_idx < r_len);
    assign size_zero = (r_size == '0);
    assign run_next  = r_run_len + 1'b1;
    assign start_next = (r_run_len == '0) ? r_idx : r_run_start;

    // size zero takes the first free cell, or the length when none is free
    always_comb begin
        if (size_zero) begin
            hit_now = !scan_ok || cell_free;
            pos_now = scan_ok ? r_idx : r_len;
        end else begin
            hit_now = scan_ok && cell_free && (run_next == r_size);
            pos_now = start_next;
        end
    end

    assign grow_sum = {1'b0, r_len} + (LEN_W + 1)'(GROW_STEP);
    assign n_len    = (grow_sum > (LEN_W + 1)'(CAPACITY)) ? LEN_W'(CAPACITY)
                                                          : grow_sum[LEN_W-1:0];

    always_comb begin
        flags.in_valid = i_item.valid;
        flags.is_alloc = (r_act == ACT_ALLOC);
        flags.is_free  = (r_act == ACT_FREE);
        flags.is_write = (r_act == ACT_WRITE);
        flags.addr_oor = (r_addr >= r_len);
        flags.scan_end = !scan_ok || hit_now;
        flags.hit      = r_hit;
        flags.no_grow  = !r_grow || (r_len >= LEN_W'(CAPACITY));
        flags.free_end = !scan_ok || (cell_q == STOP_CODE);
        flags.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow      <= 1'b1;
            r_len       <= LEN_W'(RESET_LEN);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grow <= i_cfg_wdata;
            end

            if (accept) begin
                r_act     <= i_item.action;
                r_size    <= i_item.alloc_size;
                r_val     <= i_item.cell_value;
                r_addr    <= (i_item.action == ACT_ALLOC) ? '0
                                                          : {1'b0, i_item.cell_address};
                r_run_len <= '0;
                r_hit     <= 1'b0;
                r_status  <= ST_OK;
                r_pos     <= '0;
                r_rd      <= '0;
            end

            // read pipeline: r_idx names the cell whose data shows on cell_q
            if (ctrl.rd_en) begin
                r_addr <= r_addr + 1'b1;
                r_idx  <= r_addr;
            end

            if (ctrl.scan) begin
                if (scan_ok) begin
                    if (cell_free) begin
                        r_run_len   <= run_next;
                        r_run_start <= start_next;
                    end else begin
                        r_run_len <= '0;
                    end
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                    r_pos <= pos_now;
                end
            end

            // new cells are free, so the open run carries on into them
            if (ctrl.grow) begin
                r_len  <= n_len;
                r_addr <= r_len;
            end

            if (ctrl.cap_rd) begin
                r_rd <= cell_q;
            end
            if (ctrl.set_range) begin
                r_status <= ST_RANGE;
            end
            if (ctrl.set_nofit) begin
                r_status <= ST_NOFIT;
            end

            if (ctrl.out_load && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_pos    <= r_pos;
                r_out_rd     <= r_rd;
                r_out_len    <= r_len;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_item.ready           = ctrl.ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.position      = r_out_pos;
    assign o_result.read_value    = r_out_rd;
    assign o_result.length_in_use = r_out_len;

    `FFCA_ASSERT(a_len_bounds, i_clk, i_rst_n, r_len >= LEN_W'(RESET_LEN) && r_len <= LEN_W'(CAPACITY), "length in use out of bounds")
    `FFCA_ASSERT(a_len_grows_only, i_clk, i_rst_n, $past(i_rst_n) |-> r_len >= $past(r_len), "length in use shrank")
    `FFCA_ASSERT(a_nofit_pos, i_clk, i_rst_n, r_out_valid && r_out_status == ST_NOFIT |-> r_out_pos == '0, "no-fit result carries a position")

endmodule

### tb/first_fit_cell_allocator_chk.sv
module first_fit_cell_allocator_chk import ffca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    ffca_in_if   i_item,
    ffca_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_nofit_count,
    output int   o_range_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]        status;
        logic [LEN_W-1:0]  position;
        logic [CELL_W-1:0] read_value;
        logic [LEN_W-1:0]  length_in_use;
    } t_outcome;

    // shadow copy of the cell store, length in use and grow_on_miss
    logic [CELL_W-1:0] cells [CAPACITY];
    int                span;
    bit                grow_en;
    t_outcome          expected_results [$];

    function automatic bit first_free_run(input int want, output int at);
        int i;
        int t;
        i  = 0;
        at = 0;
        if (want == 0) begin
            while (i < span && cells[i] != FREE_CODE) i++;
            at = i;
            return 1'b1;
        end
        while (i < span) begin
            if (cells[i] != FREE_CODE) begin
                i++;
                continue;
            end
            t = 0;
            while (i + t < span && cells[i + t] == FREE_CODE && t < want) t++;
            if (t == want) begin
                at = i;
                return 1'b1;
            end
            i += t;
        end
        return 1'b0;
    endfunction

    function automatic void extend_length();
        int n;
        n = span + GROW_STEP;
        if (n > CAPACITY) n = CAPACITY;
        for (int i = span; i < n; i++) cells[i] = FREE_CODE;
        span = n;
    endfunction

    function automatic t_outcome predict_outcome(input logic [1:0] act,
                                                 input logic [LEN_W-1:0] size,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [CELL_W-1:0] value);
        t_outcome r;
        bit       hit;
        int       p;
        int       i;
        r.status     = ST_OK;
        r.position   = '0;
        r.read_value = '0;
        case (act)
            ACT_ALLOC: begin
                hit = first_free_run(int'(size), p);
                while (!hit && grow_en && span < CAPACITY) begin
                    extend_length();
                    hit = first_free_run(int'(size), p);
                end
                if (hit) r.position = LEN_W'(p);
                else r.status = ST_NOFIT;
            end
            ACT_FREE: begin
                // clear through the stop code, or to the end of the length in use
                i = int'(addr);
                while (i < span && cells[i] != STOP_CODE) begin
                    cells[i] = FREE_CODE;
                    i++;
                end
                if (i < span) cells[i] = FREE_CODE;
            end
            default: begin
                if (int'(addr) >= span) r.status = ST_RANGE;
                else if (act == ACT_WRITE) cells[addr] = value;
                else r.read_value = cells[addr];
            end
        endcase
        r.length_in_use = LEN_W'(span);
        return r;
    endfunction

    task automatic report_field(input string field, input int unsigned want,
                                input logic [7:0] got, inout bit bad);
        if (got !== 8'(want)) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        bit       bad;
        if (!i_rst_n) begin
            foreach (cells[i]) cells[i] = FREE_CODE;
            span    = RESET_LEN;
            grow_en = 1'b1;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) grow_en = i_cfg_wdata;
            if (i_item.valid && i_item.ready) begin
                want = predict_outcome(i_item.action, i_item.alloc_size,
                                       i_item.cell_address, i_item.cell_value);
                if (want.status == ST_NOFIT) o_nofit_count <= o_nofit_count + 1;
                if (want.status == ST_RANGE) o_range_count <= o_range_count + 1;
                expected_results.push_back(want);
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, status %0d position %0d",
                             $time, i_result.status, i_result.position);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    report_field("status", want.status, 8'(i_result.status), bad);
                    report_field("position", want.position, 8'(i_result.position), bad);
                    report_field("read_value", want.read_value, i_result.read_value, bad);
                    report_field("length_in_use", want.length_in_use,
                                 8'(i_result.length_in_use), bad);
                    if (bad) o_fail_count <= o_fail_count + 1;
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

### tb/first_fit_cell_allocator_tb.sv
module first_fit_cell_allocator_tb import ffca_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PHASES        = 5;
    localparam int  PHASE_WORDS   = 300;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  STALL_LIMIT   = 4000;
    localparam bit  PHASE_GROW [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ffca_in_if  item_if ();
    ffca_out_if result_if ();

    int fail_count;
    int pending;
    int nofit_count;
    int range_count;

    bit                calm;
    bit                hold_req;
    logic [1:0]        last_status;
    logic [LEN_W-1:0]  last_pos;
    int                act_count [4];
    int                words_sent;
    int                cfg_writes;
    logic [ADDR_W-1:0] word_starts [$];

    first_fit_cell_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    first_fit_cell_allocator_chk chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (item_if),
        .i_result      (result_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_nofit_count (nofit_count),
        .o_range_count (range_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [1:0] act, input logic [LEN_W-1:0] size,
                             input logic [ADDR_W-1:0] addr, input logic [CELL_W-1:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.action       <= act;
        item_if.alloc_size   <= size;
        item_if.cell_address <= addr;
        item_if.cell_value   <= value;
        do @(posedge i_clk); while (!item_if.ready);
        act_count[act]++;
        words_sent++;
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_grow(input logic v);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // alloc a run, then fill it with a word that ends in the stop code
    task automatic run_word();
        int               s;
        int               base;
        logic [CELL_W-1:0] b;
        case ($urandom_range(0, 9))
            0:       s = 0;
            1:       s = $urandom_range(7, 24);
            default: s = $urandom_range(1, 6);
        endcase
        send_item(ACT_ALLOC, LEN_W'(s), $urandom, $urandom);
        wait_drained();
        if (last_status == ST_OK && s > 0) begin
            base = int'(last_pos);
            word_starts.push_back(ADDR_W'(base));
            for (int k = 0; k < s; k++) begin
                b = $urandom;
                if ($urandom_range(0, 9) != 0) begin
                    while (b == FREE_CODE || b == STOP_CODE) b = $urandom;
                end
                if (k == s - 1) b = STOP_CODE;
                send_item(ACT_WRITE, $urandom, ADDR_W'(base + k), b);
            end
            if ($urandom_range(0, 3) == 0) send_item(ACT_READ, $urandom, ADDR_W'(base), $urandom);
        end
    endtask

    initial begin : stimulus
        int                r;
        int                k;
        int                quota;
        logic [ADDR_W-1:0] a;
        logic [CELL_W-1:0] b;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_wdata          <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.action       <= ACT_ALLOC;
        item_if.alloc_size   <= '0;
        item_if.cell_address <= '0;
        item_if.cell_value   <= '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset length, first without growth
        set_grow(1'b0);
        send_item(ACT_ALLOC, 0, 0, 0);
        send_item(ACT_ALLOC, 3, 0, 0);
        send_item(ACT_WRITE, 0, 0, 8'h41);
        send_item(ACT_WRITE, 0, 1, 8'h00);
        send_item(ACT_WRITE, 0, 2, STOP_CODE);
        send_item(ACT_READ, 0, 2, 0);
        send_item(ACT_WRITE, 0, 9, 8'hFF);
        send_item(ACT_WRITE, 0, 10, 8'hAA);
        send_item(ACT_READ, 0, 63, 0);
        send_item(ACT_ALLOC, 8, 0, 0);
        send_item(ACT_ALLOC, 127, 0, 0);
        for (int i = 3; i < 9; i++) send_item(ACT_WRITE, 0, ADDR_W'(i), CELL_W'(8'h10 + i));
        // no free cell left: size zero returns the length
        send_item(ACT_ALLOC, 0, 0, 0);
        send_item(ACT_FREE, 0, 40, 0);
        send_item(ACT_FREE, 0, 0, 0);
        // no stop code from here on: clears to the end
        send_item(ACT_FREE, 0, 3, 0);
        send_item(ACT_WRITE, 0, 4, STOP_CODE);
        send_item(ACT_READ, 0, 4, 0);
        send_item(ACT_WRITE, 0, 5, FREE_CODE);
        set_grow(1'b1);
        send_item(ACT_ALLOC, 15, 63, 8'hFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_grow(PHASE_GROW[ph]);
            calm = (ph == 3);
            if (ph == 1) send_item(ACT_ALLOC, 127, 0, 0);
            if (ph == 2) hold_req = 1'b1;
            quota = words_sent + PHASE_WORDS;
            while (words_sent < quota) begin
                if (ph == 4 && $urandom_range(0, 59) == 0) calm = !calm;
                r = $urandom_range(0, 99);
                if (r < 40 && word_starts.size() < 10) begin
                    run_word();
                end else if (r < 65 && word_starts.size() > 0) begin
                    k = $urandom_range(0, word_starts.size() - 1);
                    a = word_starts[k];
                    word_starts.delete(k);
                    send_item(ACT_FREE, $urandom, a, $urandom);
                end else if (r < 75) begin
                    send_item(ACT_READ, $urandom, $urandom_range(0, 63), $urandom);
                end else begin
                    case ($urandom_range(0, 7))
                        0:       b = FREE_CODE;
                        1:       b = STOP_CODE;
                        2:       b = 8'h00;
                        3:       b = 8'hFF;
                        default: b = $urandom;
                    endcase
                    send_item($urandom_range(0, 3),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 64),
                              $urandom_range(0, 63), b);
                end
            end
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("run covered %0d words: alloc %0d, free %0d, write %0d, read %0d, %0d cfg writes",
                 words_sent, act_count[ACT_ALLOC], act_count[ACT_FREE],
                 act_count[ACT_WRITE], act_count[ACT_READ], cfg_writes);
        $display("no-fit results %0d, out-of-range results %0d, bad results %0d",
                 nofit_count, range_count, fail_count);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall per word, one long hold-off on request
    initial begin : drain
        int stall;
        result_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (!result_if.valid);
            last_status = result_if.status;
            last_pos    = result_if.position;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        do @(posedge i_clk); while (!i_rst_n);
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/ffca_pkg.sv
hdl/ffca_if.sv
hdl/ffca_cell_mem.sv
hdl/ffca_useq.sv
hdl/first_fit_cell_allocator.sv
tb/first_fit_cell_allocator_chk.sv
tb/first_fit_cell_allocator_tb.sv
